// ===== hw/rtl/pbr_pkg.sv =====
package pbr_pkg;

   localparam int MAX_COLS_DEF = 256;
   localparam int MAX_ROWS_DEF = 256;
   localparam int QUEUE_DEPTH  = 2;

   localparam int SIZE_W      = 9;
   localparam int COORD_W     = 9;
   localparam int ROW_F_W     = 8;
   localparam int BCOL_F_W    = 5;
   localparam int BYTE_W      = 8;
   localparam int CNT_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 8;

   localparam int ROW_LSB  = 0;
   localparam int BCOL_LSB = ROW_LSB + ROW_F_W;
   localparam int WDAT_LSB = BCOL_LSB + BCOL_F_W;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd2;

   localparam logic [1:0] MODE_R90  = 2'd0;
   localparam logic [1:0] MODE_R180 = 2'd1;
   localparam logic [1:0] MODE_R270 = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RST = 9'd256;

   typedef enum logic [1:0] {KIND_SKIP, KIND_WRITE, KIND_READ} kind_type;
   typedef enum logic [1:0] {STEP_YINC, STEP_YDEC, STEP_XDEC} step_type;

   typedef struct packed {
      kind_type             kind;
      step_type             step;
      logic [CNT_W-1:0]     nbits;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [BYTE_W-1:0]    wdata;
   } entry_type;

   // zero acts as one, anything above the store limit acts as the limit
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                  input int max_v);
      logic [12:0] v_ext;
      v_ext = 13'(v);
      if (v == '0) return SIZE_W'(1);
      if (v_ext > 13'(max_v)) return SIZE_W'(max_v);
      return v;
   endfunction

endpackage

// ===== hw/rtl/pbr_ram.sv =====
module pbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/pbr_front.sv =====
module pbr_front #(
   parameter int MAX_COLS = pbr_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = pbr_pkg::MAX_ROWS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pbr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,
   input  logic [pbr_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               push_valid,
   input  logic                               push_ready,
   output pbr_pkg::entry_type                 push_data
);
   import pbr_pkg::*;

   localparam int BPL = (MAX_COLS + 7) / 8;

   logic [1:0]          mode_ff, mode_in;
   logic [SIZE_W-1:0]   cols_ff, cols_in;
   logic [SIZE_W-1:0]   rows_ff, rows_in;

   logic [ROW_F_W-1:0]  row;
   logic [BCOL_F_W-1:0] bcol;
   logic [BYTE_W-1:0]   wdata;
   logic [SIZE_W-1:0]   w, h, dw, dh, p0, rem, row_e;
   logic                in_rng, write_ok;

   always_comb begin
      mode_in = mode_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         priority if (csr_index == CSR_MODE) begin
            mode_in = csr_wdata[1:0];
         end else if (csr_index == CSR_COLS) begin
            cols_in = csr_wdata;
         end else if (csr_index == CSR_ROWS) begin
            rows_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_R90;
         cols_ff <= SIZE_RST;
         rows_ff <= SIZE_RST;
      end else begin
         mode_ff <= mode_in;
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   assign row   = req_tdata[ROW_LSB +: ROW_F_W];
   assign bcol  = req_tdata[BCOL_LSB +: BCOL_F_W];
   assign wdata = req_tdata[WDAT_LSB +: BYTE_W];

   assign w     = eff_size(cols_ff, MAX_COLS);
   assign h     = eff_size(rows_ff, MAX_ROWS);
   assign dw    = (mode_ff == MODE_R180) ? w : h;
   assign dh    = (mode_ff == MODE_R180) ? h : w;
   assign p0    = {1'b0, bcol, 3'b000};
   assign row_e = SIZE_W'(row);
   assign rem   = dw - p0;

   assign in_rng   = (mode_ff != MODE_NONE) && (row_e < dh) && (p0 < dw);
   assign write_ok = (13'(row) < 13'(MAX_ROWS)) && (13'(bcol) < 13'(BPL));

   always_comb begin
      push_data       = '0;
      push_data.wdata = wdata;
      if (req_tuser == OP_READ) begin
         push_data.kind  = KIND_READ;
         push_data.nbits = !in_rng ? CNT_W'(0) :
                           (rem >= SIZE_W'(8)) ? CNT_W'(8) : rem[CNT_W-1:0];
         unique case (mode_ff)
            MODE_R90: begin
               push_data.x    = w - SIZE_W'(1) - row_e;
               push_data.y    = p0;
               push_data.step = STEP_YINC;
            end
            MODE_R180: begin
               push_data.x    = w - SIZE_W'(1) - p0;
               push_data.y    = h - SIZE_W'(1) - row_e;
               push_data.step = STEP_XDEC;
            end
            MODE_R270: begin
               push_data.x    = row_e;
               push_data.y    = h - SIZE_W'(1) - p0;
               push_data.step = STEP_YDEC;
            end
            MODE_NONE: begin
               push_data.step = STEP_YINC;
            end
         endcase
      end else begin
         push_data.kind = write_ok ? KIND_WRITE : KIND_SKIP;
         push_data.x    = p0;
         push_data.y    = row_e;
         push_data.step = STEP_YINC;
      end
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

// ===== hw/rtl/pbr_queue.sv =====
module pbr_queue #(
   parameter int DEPTH = pbr_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  pbr_pkg::entry_type  push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output pbr_pkg::entry_type  pop_data
);
   import pbr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               do_push, do_pop;

   assign push_ready = (fill_ff != FILL_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/pbr_back.sv =====
module pbr_back #(
   parameter int MAX_COLS = pbr_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = pbr_pkg::MAX_ROWS_DEF,
   parameter int ADDR_W   = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  pbr_pkg::entry_type               pop_data,
   output logic                             ram_we,
   output logic [ADDR_W-1:0]                ram_waddr,
   output logic [pbr_pkg::BYTE_W-1:0]       ram_wdata,
   output logic                             ram_re,
   output logic [ADDR_W-1:0]                ram_raddr,
   input  logic [pbr_pkg::BYTE_W-1:0]       ram_rdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pbr_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import pbr_pkg::*;

   localparam int BPL    = (MAX_COLS + 7) / 8;
   localparam int BCOL_W = (BPL > 1) ? $clog2(BPL) : 1;
   localparam int ROW_W  = $clog2(MAX_ROWS);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_type;

   state_type           state_ff, state_in;
   logic [COORD_W-1:0]  x_ff, x_in, y_ff, y_in;
   step_type            step_ff, step_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [2:0]          pos_ff, pos_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [2:0]          rd_sel_ff, rd_sel_in;
   logic [2:0]          rd_pos_ff, rd_pos_in;
   logic [BYTE_W-1:0]   acc_ff, acc_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [BYTE_W-1:0]   rsp_dat_ff, rsp_dat_in;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
      logic [12:0] xb;
      logic [12:0] ye;
      xb = 13'(x[COORD_W-1:3]);
      ye = 13'(y);
      return {ye[ROW_W-1:0], xb[BCOL_W-1:0]};
   endfunction

   assign pop_ready = (state_ff == ST_IDLE);
   assign ram_we    = pop_ready && pop_valid && (pop_data.kind == KIND_WRITE);
   assign ram_waddr = addr_of(pop_data.x, pop_data.y);
   assign ram_wdata = pop_data.wdata;
   assign ram_re    = (state_ff == ST_RUN);
   assign ram_raddr = addr_of(x_ff, y_ff);

   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      step_in    = step_ff;
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      rd_vld_in  = 1'b0;
      rd_sel_in  = rd_sel_ff;
      rd_pos_in  = rd_pos_ff;
      acc_in     = acc_ff;
      rsp_vld_in = rsp_vld_ff;
      rsp_dat_in = rsp_dat_ff;

      if (rd_vld_ff) begin
         acc_in[~rd_pos_ff] = ram_rdata[rd_sel_ff];
      end
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid && (pop_data.kind == KIND_READ)) begin
               acc_in  = '0;
               x_in    = pop_data.x;
               y_in    = pop_data.y;
               step_in = pop_data.step;
               cnt_in  = pop_data.nbits;
               pos_in  = '0;
               state_in = (pop_data.nbits == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            rd_vld_in = 1'b1;
            rd_sel_in = ~x_ff[2:0];
            rd_pos_in = pos_ff;
            pos_in    = pos_ff + 3'd1;
            cnt_in    = cnt_ff - CNT_W'(1);
            case (step_ff)
               STEP_YINC: y_in = y_ff + COORD_W'(1);
               STEP_YDEC: y_in = y_ff - COORD_W'(1);
               STEP_XDEC: x_in = x_ff - COORD_W'(1);
               default:   x_in = x_ff;
            endcase
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               rsp_dat_in = acc_ff;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      x_ff       <= x_in;
      y_ff       <= y_in;
      step_ff    <= step_in;
      cnt_ff     <= cnt_in;
      pos_ff     <= pos_in;
      rd_sel_ff  <= rd_sel_in;
      rd_pos_ff  <= rd_pos_in;
      acc_ff     <= acc_in;
      rsp_dat_ff <= rsp_dat_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_dat_ff;

endmodule

// ===== hw/rtl/packed_bitmap_rotate_top.sv =====
// channel  | direction | tvalid/tready | tuser       | tdata (lsb first)
// req      | in        | req_          | op          | row[7:0] byte_col[12:8] wdata[20:13]
// rsp      | out       | rsp_          | -           | rotated_byte[7:0]
// csr      | in        | csr_we        | -           | csr_index, csr_wdata (9 bits)
//
// Write items go to the store in the cycle they are popped. A read is popped,
// then reads one source byte for each of its 0..8 valid result bits, waits
// for the last read data and loads the result byte (zero when no bit is valid).
// A two-entry queue lets requests keep arriving while the back end works;
// a result held by a stalled receiver keeps the back end from loading the next result.
// Synchronous reset clears control only; the store is not cleared.
module packed_bitmap_rotate_top #(
   parameter int MAX_COLS = pbr_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = pbr_pkg::MAX_ROWS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pbr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,  // op
   input  logic [pbr_pkg::REQ_TDATA_W-1:0]  req_tdata,  // row, byte_col, wdata
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pbr_pkg::RSP_TDATA_W-1:0]  rsp_tdata   // rotated_byte
);
   import pbr_pkg::*;

   localparam int BPL    = (MAX_COLS + 7) / 8;
   localparam int BCOL_W = (BPL > 1) ? $clog2(BPL) : 1;
   localparam int DEPTH  = MAX_ROWS * (1 << BCOL_W);
   localparam int ADDR_W = $clog2(DEPTH);

   entry_type           push_data, pop_data;
   logic                push_valid, push_ready, pop_valid, pop_ready;
   logic                ram_we, ram_re;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [BYTE_W-1:0]   ram_wdata, ram_rdata;

   pbr_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   pbr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pbr_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .ADDR_W(ADDR_W)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pbr_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

// ===== hw/rtl/pbr_checker.sv =====
module pbr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             csr_we,
   input logic [pbr_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [pbr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pbr_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import pbr_pkg::*;

   logic [1:0] mode_ff;
   logic [3:0] pend_ff;
   logic       rd_acc, rsp_acc;

   assign rd_acc  = req_tvalid && req_tready && (req_tuser == OP_READ);
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_R90;
         pend_ff <= '0;
      end else begin
         if (csr_we && (csr_index == CSR_MODE)) begin
            mode_ff <= csr_wdata[1:0];
         end
         pend_ff <= pend_ff + 4'(rd_acc) - 4'(rsp_acc);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 4'd0)
      else $error("result without an outstanding read");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 4'(QUEUE_DEPTH + 2))
      else $error("more reads in flight than the design can hold");

   a_mode_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (mode_ff == MODE_NONE) |-> rsp_tdata == '0)
      else $error("unused mode gave a nonzero byte");

endmodule

bind packed_bitmap_rotate_top pbr_checker u_pbr_checker (.*);
